[design/sldf_pkg.sv]
// Package with the phase type, reset values and register map of the sync/length/sum deframer.
`timescale 1ns / 1ps
`default_nettype none

package sldf_pkg;

   typedef enum logic [1:0] {
      PH_HUNT    = 2'd0,
      PH_LEN     = 2'd1,
      PH_PAYLOAD = 2'd2,
      PH_CSUM    = 2'd3
   } phase_type;

   localparam int          BYTE_W      = 8;
   localparam int          ADDR_W      = 3;
   localparam int          DATA_W      = 32;
   localparam logic [7:0]  SYNC_RESET  = 8'hA4;
   localparam logic [0:0]  REG_SYNC_VALUE = 1'b0;

endpackage

`default_nettype wire

[design/sync_length_sum_deframer.sv]
// Top level of the sync/length/sum deframer: input stage, frame state machine and result register.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake            Word
// req       in         req_valid/req_stall  req_rx_byte
// rsp       out        rsp_valid/rsp_stall  data, index, end, ok, length, sum
// csr       in/out     psel/penable/pready  sync_value at byte address 0
//
// A byte that gives a result passes from the input register to the result register;
// one byte is accepted per cycle when the output drains.
// Sync, length and non-sync hunting bytes give no result and never stall.
// A byte that gives a result waits in the input register, and stalls the input, while
// the result register holds a stalled word.
// Reset is synchronous and active high; it returns to hunting and restores sync_value.
module sync_length_sum_deframer (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [7:0]                  req_rx_byte,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [7:0]                       rsp_data_byte,
   output logic [7:0]                       rsp_byte_index,
   output logic                             rsp_frame_end,
   output logic                             rsp_sum_ok,
   output logic [7:0]                       rsp_payload_length,
   output logic [7:0]                       rsp_computed_sum,
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [sldf_pkg::ADDR_W-1:0] paddr,
   input  wire logic [sldf_pkg::DATA_W-1:0] pwdata,
   output logic [sldf_pkg::DATA_W-1:0]      prdata,
   output logic                             pready
);

   logic [7:0]          sync_ff;
   logic                s1_valid_ff;
   logic [7:0]          s1_byte_ff;
   sldf_pkg::phase_type phase_ff, phase_in;
   logic [7:0]          len_ff, len_in;
   logic [7:0]          count_ff, count_in;
   logic [7:0]          sum_ff, sum_in;
   logic [7:0]          new_sum;
   logic [7:0]          new_count;
   logic                has_result;
   logic                s1_advance;
   logic                req_take;
   logic                out_valid_ff;
   logic [7:0]          out_data_ff, out_index_ff, out_len_ff, out_sum_ff;
   logic                out_end_ff, out_ok_ff;
   logic                reg_sel;

   assign pready  = 1'b1;
   assign reg_sel = (paddr[2] == sldf_pkg::REG_SYNC_VALUE);
   assign prdata  = reg_sel ? {{(sldf_pkg::DATA_W-8){1'b0}}, sync_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff <= sldf_pkg::SYNC_RESET;
      end else if (psel && penable && pwrite && reg_sel) begin
         sync_ff <= pwdata[7:0];
      end
   end

   assign has_result = (phase_ff == sldf_pkg::PH_PAYLOAD) || (phase_ff == sldf_pkg::PH_CSUM);
   assign s1_advance = s1_valid_ff && (!has_result || !out_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !s1_advance;
   assign req_take   = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_take) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_byte_ff <= req_rx_byte;
      end
   end

   assign new_sum   = sum_ff + s1_byte_ff;
   assign new_count = count_ff + 8'd1;

   always_comb begin
      phase_in = phase_ff;
      len_in   = len_ff;
      count_in = count_ff;
      sum_in   = sum_ff;
      if (s1_advance) begin
         unique case (phase_ff)
            sldf_pkg::PH_HUNT: begin
               if (s1_byte_ff == sync_ff) begin
                  sum_in   = s1_byte_ff;
                  count_in = 8'd0;
                  phase_in = sldf_pkg::PH_LEN;
               end
            end
            sldf_pkg::PH_LEN: begin
               len_in   = s1_byte_ff;
               sum_in   = new_sum;
               count_in = 8'd0;
               phase_in = (s1_byte_ff == 8'd0) ? sldf_pkg::PH_CSUM : sldf_pkg::PH_PAYLOAD;
            end
            sldf_pkg::PH_PAYLOAD: begin
               sum_in   = new_sum;
               count_in = new_count;
               if (new_count == len_ff) begin
                  phase_in = sldf_pkg::PH_CSUM;
               end
            end
            sldf_pkg::PH_CSUM: begin
               phase_in = sldf_pkg::PH_HUNT;
            end
            default: begin
               phase_in = sldf_pkg::PH_HUNT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= sldf_pkg::PH_HUNT;
         len_ff   <= 8'd0;
         count_ff <= 8'd0;
         sum_ff   <= 8'd0;
      end else begin
         phase_ff <= phase_in;
         len_ff   <= len_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_advance && has_result) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance && has_result) begin
         out_data_ff <= s1_byte_ff;
         out_len_ff  <= len_ff;
         if (phase_ff == sldf_pkg::PH_PAYLOAD) begin
            out_index_ff <= count_ff;
            out_end_ff   <= 1'b0;
            out_ok_ff    <= 1'b0;
            out_sum_ff   <= new_sum;
         end else begin
            out_index_ff <= 8'd0;
            out_end_ff   <= 1'b1;
            out_ok_ff    <= (s1_byte_ff == sum_ff);
            out_sum_ff   <= sum_ff;
         end
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_data_byte      = out_data_ff;
   assign rsp_byte_index     = out_index_ff;
   assign rsp_frame_end      = out_end_ff;
   assign rsp_sum_ok         = out_ok_ff;
   assign rsp_payload_length = out_len_ff;
   assign rsp_computed_sum   = out_sum_ff;

endmodule

`default_nettype wire

[design/sldf_checker.sv]
// Port-level checker for the sync/length/sum deframer and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

module sldf_port_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [7:0] rsp_data_byte,
   input wire logic [7:0] rsp_byte_index,
   input wire logic       rsp_frame_end,
   input wire logic       rsp_sum_ok,
   input wire logic [7:0] rsp_payload_length,
   input wire logic [7:0] rsp_computed_sum
);

   // A stalled result word holds until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data_byte)
         && $stable(rsp_byte_index) && $stable(rsp_frame_end) && $stable(rsp_sum_ok)
         && $stable(rsp_payload_length) && $stable(rsp_computed_sum))
      else $error("rsp word changed while stalled");

   // Reset leaves no result pending.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // A payload word never claims a checksum pass and lies inside the frame.
   a_payload_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_frame_end |-> !rsp_sum_ok && (rsp_byte_index < rsp_payload_length))
      else $error("payload word with bad flag or index");

   // The end word carries index zero and passes exactly when the sums match.
   a_end_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |-> (rsp_byte_index == 8'd0)
         && (rsp_sum_ok == (rsp_data_byte == rsp_computed_sum)))
      else $error("end word with bad index or pass flag");

endmodule

bind sync_length_sum_deframer sldf_port_checker u_sldf_port_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_data_byte      (rsp_data_byte),
   .rsp_byte_index     (rsp_byte_index),
   .rsp_frame_end      (rsp_frame_end),
   .rsp_sum_ok         (rsp_sum_ok),
   .rsp_payload_length (rsp_payload_length),
   .rsp_computed_sum   (rsp_computed_sum)
);

`default_nettype wire
